// ===== rtl/kwsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyword substitution cipher package
// Shared widths, character codes, register map and configuration types.
// ----------------------------------------------------------------------------
`default_nettype none

package kwsc_pkg;

  localparam int unsigned ALPHABET_SIZE       = 26;
  localparam int unsigned KEY_REGS            = 5;
  localparam int unsigned DEF_MAX_KEY_LETTERS = 5;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned LETTER_W    = 5;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned KEY_IDX_W   = 3;
  localparam int unsigned CFG_ADDR_W  = 5;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(ALPHABET_SIZE - 1);

  localparam logic [CHAR_W-1:0] CHAR_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UP_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LO_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_CASE   = 8'h20;

  typedef enum logic [KEY_IDX_W-1:0] {
    REG_KEY_A  = 3'd0,
    REG_KEY_B  = 3'd1,
    REG_KEY_C  = 3'd2,
    REG_KEY_D  = 3'd3,
    REG_KEY_E  = 3'd4,
    REG_COUNT  = 3'd5,
    REG_MODE   = 3'd6
  } kwsc_reg_t;

  typedef struct packed {
    logic [KEY_REGS-1:0][LETTER_W-1:0] key_letter;
    logic [COUNT_W-1:0]                key_count;
    logic                              decrypt_mode;
  } kwsc_cfg_t;

  localparam logic [COUNT_W-1:0] RST_KEY_COUNT = COUNT_W'(KEY_REGS);

endpackage

`default_nettype wire

// ===== rtl/kwsc_map.sv =====
// ----------------------------------------------------------------------------
// Keyword substitution character mapper
// Ranks one character against the key alphabet and substitutes it.
// ----------------------------------------------------------------------------
`default_nettype none

module kwsc_map
  import kwsc_pkg::*;
#(
  parameter int unsigned MAX_KEY_LETTERS = DEF_MAX_KEY_LETTERS
) (
  input  kwsc_cfg_t          cfg,
  input  logic [CHAR_W-1:0]  char_i,
  output logic [CHAR_W-1:0]  char_o,
  output logic               fault_o
);

  localparam int unsigned KEY_LIM =
    (MAX_KEY_LETTERS < KEY_REGS) ? MAX_KEY_LETTERS : KEY_REGS;
  localparam logic [COUNT_W-1:0] KEY_LIM_C = COUNT_W'(KEY_LIM);

  logic [COUNT_W-1:0]                     n_used;
  logic [KEY_REGS-1:0][LETTER_W-1:0]      sat;
  logic [KEY_REGS-1:0]                    in_use;
  logic                                   fault;
  logic [ALPHABET_SIZE-1:0]               taken;
  logic [ALPHABET_SIZE-1:0][COUNT_W-1:0]  below;
  logic [CHAR_W-1:0]                      low_char;
  logic [CHAR_W-1:0]                      ofs;
  logic                                   is_letter;
  logic [LETTER_W-1:0]                    idx;
  logic [LETTER_W-1:0]                    rank;
  logic [LETTER_W-1:0]                    enc_val;
  logic [LETTER_W-1:0]                    dec_val;
  logic [LETTER_W-1:0]                    res;

  always_comb begin
    if (cfg.key_count == '0) begin
      n_used = COUNT_W'(1);
    end else if (cfg.key_count > KEY_LIM_C) begin
      n_used = KEY_LIM_C;
    end else begin
      n_used = cfg.key_count;
    end

    for (int k = 0; k < KEY_REGS; k++) begin
      sat[k]    = (cfg.key_letter[k] > LAST_LETTER) ? LAST_LETTER : cfg.key_letter[k];
      in_use[k] = COUNT_W'(k) < n_used;
    end

    fault = 1'b0;
    for (int k = 1; k < KEY_REGS; k++) begin
      for (int j = 0; j < k; j++) begin
        if (in_use[k] && in_use[j] && (sat[k] == sat[j])) begin
          fault = 1'b1;
        end
      end
    end

    for (int c = 0; c < ALPHABET_SIZE; c++) begin
      taken[c] = 1'b0;
      below[c] = '0;
      for (int k = 0; k < KEY_REGS; k++) begin
        if (in_use[k] && (sat[k] == LETTER_W'(c))) begin
          taken[c] = 1'b1;
        end
        if (in_use[k] && (sat[k] < LETTER_W'(c))) begin
          below[c] = below[c] + COUNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    if ((char_i >= CHAR_UP_A) && (char_i <= CHAR_UP_Z)) begin
      low_char = char_i | CHAR_CASE;
    end else begin
      low_char = char_i;
    end
    is_letter = (low_char >= CHAR_LO_A) && (low_char <= CHAR_LO_Z);
    ofs       = low_char - CHAR_LO_A;
    idx       = is_letter ? ofs[LETTER_W-1:0] : '0;
    rank      = idx - LETTER_W'(n_used);

    enc_val = '0;
    if (idx < LETTER_W'(n_used)) begin
      enc_val = sat[idx[KEY_IDX_W-1:0]];
    end else begin
      for (int c = 0; c < ALPHABET_SIZE; c++) begin
        if (!taken[c] && ((LETTER_W'(c) - LETTER_W'(below[c])) == rank)) begin
          enc_val = enc_val | LETTER_W'(c);
        end
      end
    end

    dec_val = '0;
    if (taken[idx]) begin
      for (int k = 0; k < KEY_REGS; k++) begin
        if (in_use[k] && (sat[k] == idx)) begin
          dec_val = dec_val | LETTER_W'(k);
        end
      end
    end else begin
      dec_val = LETTER_W'(n_used) + idx - LETTER_W'(below[idx]);
    end

    res = cfg.decrypt_mode ? dec_val : enc_val;

    if (is_letter && !fault) begin
      char_o = CHAR_LO_A + {{(CHAR_W-LETTER_W){1'b0}}, res};
    end else begin
      char_o = low_char;
    end
    fault_o = fault;
  end

endmodule

`default_nettype wire

// ===== rtl/keyword_substitution_cipher.sv =====
// A character accepted into the input register is ranked and substituted, and the result is
// registered into the output register, where the receiver takes it with out_valid.
// Throughput: one character per cycle; busy is never raised and results cannot be stalled.
// The rate is set by a single registered pass through the rank and substitution logic.
// Reset clears the pipeline valid flags and loads the key letters a to e, count five, encrypt.
// ----------------------------------------------------------------------------
// Keyword substitution cipher
// Register-bounded character substitution with an APB-style key register port.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_substitution_cipher
  import kwsc_pkg::*;
#(
  parameter int unsigned MAX_KEY_LETTERS = DEF_MAX_KEY_LETTERS
) (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   start,
  output logic                   busy,
  input  logic [CHAR_W-1:0]      in_char,

  output logic                   out_valid,
  output logic [CHAR_W-1:0]      out_char,
  output logic                   out_key_fault,

  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  kwsc_cfg_t            cfg_r;
  kwsc_cfg_t            cfg_nxt;
  kwsc_reg_t            reg_sel;
  logic                 cfg_wr;

  logic                 in_vld_r;
  logic [CHAR_W-1:0]    in_char_r;
  logic                 out_vld_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic                 out_fault_r;

  logic [CHAR_W-1:0]    map_char;
  logic                 map_fault;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  assign reg_sel = kwsc_reg_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_sel) inside
        REG_KEY_A, REG_KEY_B, REG_KEY_C, REG_KEY_D, REG_KEY_E: begin
          cfg_nxt.key_letter[reg_sel] = pwdata[LETTER_W-1:0];
        end
        REG_COUNT: begin
          cfg_nxt.key_count = pwdata[COUNT_W-1:0];
        end
        REG_MODE: begin
          cfg_nxt.decrypt_mode = pwdata[0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel) inside
      REG_KEY_A, REG_KEY_B, REG_KEY_C, REG_KEY_D, REG_KEY_E: begin
        prdata = CFG_DATA_W'(cfg_r.key_letter[reg_sel]);
      end
      REG_COUNT: begin
        prdata = CFG_DATA_W'(cfg_r.key_count);
      end
      REG_MODE: begin
        prdata = CFG_DATA_W'(cfg_r.decrypt_mode);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < KEY_REGS; k++) begin
        cfg_r.key_letter[k] <= LETTER_W'(k);
      end
      cfg_r.key_count    <= RST_KEY_COUNT;
      cfg_r.decrypt_mode <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  kwsc_map #(
    .MAX_KEY_LETTERS (MAX_KEY_LETTERS)
  ) u_map (
    .cfg     (cfg_r),
    .char_i  (in_char_r),
    .char_o  (map_char),
    .fault_o (map_fault)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start && !busy;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_char_r <= in_char;
    end
    if (in_vld_r) begin
      out_char_r  <= map_char;
      out_fault_r <= map_fault;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_char      = out_char_r;
  assign out_key_fault = out_fault_r;

`ifndef SYNTHESIS
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> in_vld_r)
    else $error("accepted beat did not enter the input register");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r |=> out_valid)
    else $error("input beat did not produce a result beat");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |=> !out_valid)
    else $error("result beat without an input beat");

  a_never_upper: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !((out_char >= CHAR_UP_A) && (out_char <= CHAR_UP_Z)))
    else $error("result beat carries an upper case letter");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyword substitution cipher testbench
// Drives characters through the cipher under a series of key settings written
// over the register port. A directed table comes first, then random traffic;
// each output beat is checked against a table value or a keyed alphabet model.
// ----------------------------------------------------------------------------

module tb_top;
  import kwsc_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              fault;
  } cipher_res_t;

  typedef enum logic { ROW_CHAR, ROW_CFG } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic              typed;
    logic [2:0]        reg_idx;
    logic [31:0]       value;
    logic [CHAR_W-1:0] exp_ch;
    logic              exp_fault;
  } dir_row_t;

  localparam logic [2:0] UNUSED_REG = 3'd7;
  localparam int N_DIR = 36;
  localparam int N_PHASES = 10;
  localparam int PHASE_ITEMS = 50;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [CHAR_W-1:0]     in_char = '0;
  logic                  out_valid;
  logic [CHAR_W-1:0]     out_char;
  logic                  out_key_fault;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic [LETTER_W-1:0] key_ltr [KEY_REGS];
  logic [COUNT_W-1:0]  key_cnt;
  logic                decrypt;

  cipher_res_t pending_chars [$];
  int n_sent = 0;
  int n_checked = 0;
  int n_faulted = 0;
  int n_settings = 1;
  int mismatches = 0;

  keyword_substitution_cipher i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_char       (in_char),
    .out_valid     (out_valid),
    .out_char      (out_char),
    .out_key_fault (out_key_fault),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  function automatic dir_row_t row_exp(logic [7:0] c, logic [7:0] want, logic flt);
    return '{ROW_CHAR, 1'b1, 3'd0, {24'd0, c}, want, flt};
  endfunction

  function automatic dir_row_t row_chk(logic [7:0] c);
    return '{ROW_CHAR, 1'b0, 3'd0, {24'd0, c}, 8'd0, 1'b0};
  endfunction

  function automatic dir_row_t row_cfg(logic [2:0] idx, logic [31:0] val);
    return '{ROW_CFG, 1'b0, idx, val, 8'd0, 1'b0};
  endfunction

  dir_row_t dir_rows [N_DIR] = '{
    row_exp("A", "a", 1'b0),
    row_exp("Z", "z", 1'b0),
    row_exp("a", "a", 1'b0),
    row_exp("z", "z", 1'b0),
    row_exp(8'h00, 8'h00, 1'b0),
    row_exp(8'hFF, 8'hFF, 1'b0),
    row_exp("@", "@", 1'b0),
    row_exp("{", "{", 1'b0),
    row_exp(8'h5B, 8'h5B, 1'b0),
    row_exp(8'h60, 8'h60, 1'b0),
    row_cfg(REG_KEY_A, 32'd25),
    row_cfg(REG_KEY_B, 32'd4),
    row_cfg(REG_KEY_C, 32'd1),
    row_cfg(REG_KEY_D, 32'd17),
    row_cfg(REG_KEY_E, 32'd0),
    row_chk("a"),
    row_chk("Z"),
    row_chk("m"),
    row_cfg(REG_MODE, 32'd1),
    row_chk("z"),
    row_chk("E"),
    row_cfg(REG_KEY_E, 32'd31),
    row_exp("Q", "q", 1'b1),
    row_exp(8'h80, 8'h80, 1'b1),
    row_cfg(REG_COUNT, 32'd0),
    row_chk("a"),
    row_chk("y"),
    row_cfg(REG_COUNT, 32'd7),
    row_exp("B", "b", 1'b1),
    row_cfg(UNUSED_REG, 32'hFFFF_FFFF),
    row_cfg(REG_COUNT, 32'd4),
    row_cfg(REG_MODE, 32'd0),
    row_chk("y"),
    row_chk("d"),
    row_cfg(REG_KEY_A, 32'hFFFF_FFE0),
    row_chk("c")
  };

  function automatic cipher_res_t substitute(logic [CHAR_W-1:0] c);
    logic [LETTER_W-1:0] alpha [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] taken;
    logic [LETTER_W-1:0] ltr;
    logic [CHAR_W-1:0] lc;
    cipher_res_t r;
    int n;
    int pos;
    int k;
    taken = '0;
    pos = 0;
    r.fault = 1'b0;
    n = (key_cnt == 0) ? 1 : ((key_cnt > DEF_MAX_KEY_LETTERS) ? DEF_MAX_KEY_LETTERS : key_cnt);
    for (k = 0; k < n; k++) begin
      ltr = (key_ltr[k] > LAST_LETTER) ? LAST_LETTER : key_ltr[k];
      if (taken[ltr]) begin
        r.fault = 1'b1;
      end else begin
        taken[ltr] = 1'b1;
        alpha[pos] = ltr;
        pos++;
      end
    end
    for (k = 0; k < ALPHABET_SIZE; k++) begin
      if (!taken[k]) begin
        alpha[pos] = LETTER_W'(k);
        pos++;
      end
    end
    lc = (c >= CHAR_UP_A && c <= CHAR_UP_Z) ? c + CHAR_CASE : c;
    r.ch = lc;
    if (!r.fault && lc >= CHAR_LO_A && lc <= CHAR_LO_Z) begin
      if (!decrypt) begin
        r.ch = CHAR_LO_A + CHAR_W'(alpha[lc - CHAR_LO_A]);
      end else begin
        for (k = 0; k < ALPHABET_SIZE; k++) begin
          if (alpha[k] == LETTER_W'(lc - CHAR_LO_A)) r.ch = CHAR_LO_A + CHAR_W'(k);
        end
      end
    end
    return r;
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic typed,
                           input cipher_res_t want);
    start   <= 1'b1;
    in_char <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_chars.push_back(typed ? want : substitute(c));
    n_sent++;
  endtask

  task automatic wait_idle();
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (kwsc_reg_t'(idx)) inside
      REG_KEY_A, REG_KEY_B, REG_KEY_C, REG_KEY_D, REG_KEY_E: key_ltr[idx] = data[LETTER_W-1:0];
      REG_COUNT: key_cnt = data[COUNT_W-1:0];
      REG_MODE:  decrypt = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin : check_beat
    cipher_res_t want;
    if (rst_n && out_valid) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual char %h fault %b",
                 $time, out_char, out_key_fault);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        n_checked++;
        if (out_key_fault) n_faulted++;
        if (out_char !== want.ch) begin
          $display("%0t: out_char expected %h actual %h", $time, want.ch, out_char);
          mismatches++;
        end
        if (out_key_fault !== want.fault) begin
          $display("%0t: out_key_fault expected %b actual %b", $time, want.fault, out_key_fault);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t row;
    logic [ALPHABET_SIZE-1:0] used;
    logic [LETTER_W-1:0] pick;
    logic [CHAR_W-1:0] c;
    logic [31:0] val;
    int p;
    int i;
    int k;
    int burst;
    for (k = 0; k < KEY_REGS; k++) key_ltr[k] = LETTER_W'(k);
    key_cnt = RST_KEY_COUNT;
    decrypt = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_DIR; i++) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        start <= 1'b0;
        wait_idle();
        write_reg(row.reg_idx, row.value);
        n_settings++;
      end else begin
        send_char(row.value[CHAR_W-1:0], row.typed, '{row.exp_ch, row.exp_fault});
      end
    end
    start <= 1'b0;
    wait_idle();

    for (p = 0; p < N_PHASES; p++) begin
      used = '0;
      for (k = 0; k < KEY_REGS; k++) begin
        do pick = LETTER_W'($urandom_range(0, ALPHABET_SIZE - 1)); while (used[pick]);
        used[pick] = 1'b1;
        if ($urandom_range(0, 7) == 0) pick = LETTER_W'($urandom_range(0, 31));
        write_reg(3'(k), ($urandom() & ~32'h1F) | 32'(pick));
      end
      val = (p == 0) ? 32'd1 : (p == 1) ? 32'd5 : 32'($urandom_range(0, 7));
      write_reg(REG_COUNT, ($urandom() & ~32'h7) | val);
      val = (p == 0) ? 32'd0 : (p == 1) ? 32'd1 : 32'($urandom_range(0, 1));
      write_reg(REG_MODE, ($urandom() & ~32'h1) | val);
      if ($urandom_range(0, 3) == 0) write_reg(UNUSED_REG, $urandom());
      n_settings++;

      burst = $urandom_range(1, 12);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(0, 7)) inside
          [0:2]: c = CHAR_UP_A + CHAR_W'($urandom_range(0, ALPHABET_SIZE - 1));
          [3:5]: c = CHAR_LO_A + CHAR_W'($urandom_range(0, ALPHABET_SIZE - 1));
          default: c = CHAR_W'($urandom_range(0, 255));
        endcase
        send_char(c, 1'b0, '0);
        burst--;
        if (burst == 0 && i != PHASE_ITEMS - 1) begin
          burst = $urandom_range(1, 12);
          if (p % 2 == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
          end
        end
      end
      start <= 1'b0;
      wait_idle();
    end

    repeat (8) @(posedge clk);
    $display("Sent %0d characters under %0d key settings; %0d beats checked, %0d with a bad key.",
             n_sent, n_settings, n_checked, n_faulted);
    $display("Mismatches found: %0d.", mismatches);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
